// ----- hdl/kcot_pkg.sv -----
// ----------------------------------------------------------------------------
// kcot_pkg
// Types and constants shared by the canonical k-mer context table.
// ----------------------------------------------------------------------------
package kcot_pkg;

   localparam int unsigned WIN_W = 62;
   localparam int unsigned ENTRY_W = 64;

   // slot count sits just below 2^16, so the key folds on 16-bit chunks
   localparam int unsigned TABLE_SIZE = 65521;
   localparam int unsigned AW = 16;
   localparam int unsigned FOLD_W = 28;
   localparam int unsigned POS_F1 = 65536 % TABLE_SIZE;
   localparam int unsigned POS_F2 = (POS_F1 * POS_F1) % TABLE_SIZE;
   localparam int unsigned POS_F3 = (POS_F2 * POS_F1) % TABLE_SIZE;
   localparam int unsigned STEP_F1 = 65536 % (TABLE_SIZE - 1);
   localparam int unsigned STEP_F2 = (STEP_F1 * STEP_F1) % (TABLE_SIZE - 1);
   localparam int unsigned STEP_F3 = (STEP_F2 * STEP_F1) % (TABLE_SIZE - 1);

   localparam logic [4:0] K_RESET = 5'd17;
   localparam logic [WIN_W-1:0] MASK_RESET = 62'd17179672575;

   localparam logic [0:0] CSR_TUPLE_LENGTH = 1'b0;
   localparam logic [0:0] CSR_CONTEXT_MASK = 1'b1;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_GT = 8'h3E;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_READ_OUT,
      ST_CMP,
      ST_DIV,
      ST_FIX,
      ST_PROBE,
      ST_CHECK,
      ST_STEP
   } state_type;

endpackage

// ----- hdl/kmer_context_object_table.sv -----
// A character that completes no k-mer is taken in its accepting cycle, busy stays low.
// A completed k-mer holds busy through CMP and, unless its masked context equals its
// masked reverse complement, through DIV and FIX to fold the key, then read (PROBE) and
// check (CHECK) for each probe, with a step (STEP) between probes. A table read holds busy
// through READ and READ_OUT; the result strobe is high in the first cycle busy is low. After reset
// a clearing pass zeroes every slot, one a cycle, with busy high. The result side cannot stall.
// ----------------------------------------------------------------------------
// kmer_context_object_table
// Canonical k-mer windowing of FASTA text with a double-hashed slot table.
// ----------------------------------------------------------------------------
module kmer_context_object_table
   import kcot_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_kind,
   input  logic [7:0]       req_character,
   input  logic [15:0]      req_index,
   output logic             rsp_valid,
   output logic [WIN_W-1:0] rsp_stored_tuple,
   output logic             rsp_occupied,
   output logic             rsp_conflicted,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [WIN_W-1:0] csr_data
);

   localparam logic [AW:0] TSZ = (AW+1)'(TABLE_SIZE);
   localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);
   localparam logic [17:0] RED_POS_M = 18'(TABLE_SIZE);
   localparam logic [17:0] RED_STEP_M = 18'(TABLE_SIZE - 1);

   logic [ENTRY_W-1:0] mem [TABLE_SIZE];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic rd_en;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   state_type state_ff, state_in;
   logic [4:0] k_ff, k_in;
   logic [WIN_W-1:0] mask_ff, mask_in;
   logic [WIN_W-1:0] fwd_ff, fwd_in, rev_ff, rev_in;
   logic [4:0] loaded_ff, loaded_in;
   logic hdr_ff, hdr_in;
   logic [WIN_W-1:0] uni_ff, uni_in, key_ff, key_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [FOLD_W-1:0] r1_ff, r1_in, r2_ff, r2_in;
   logic [AW-1:0] pos_ff, pos_in, step_ff, step_in;
   logic [AW-1:0] probes_ff, probes_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_W-1:0] rsp_ff, rsp_in;
   logic oor_ff, oor_in;

   logic [4:0] keff;
   logic [1:0] bcode;
   logic isbase;
   logic [WIN_W-1:0] wmask, nf, nr;
   logic [FOLD_W-1:0] fold_pos, fold_step;
   logic [17:0] red_pos, red_step;
   logic [AW+1:0] psum;

   always_comb begin
      keff = (k_ff < 5'd3) ? 5'd3 : k_ff;
      isbase = 1'b1;
      bcode = 2'd0;
      case (req_character)
         8'h41, 8'h61: bcode = 2'd0;
         8'h43, 8'h63: bcode = 2'd1;
         8'h47, 8'h67: bcode = 2'd2;
         8'h54, 8'h74: bcode = 2'd3;
         default: isbase = 1'b0;
      endcase
      wmask = ~({WIN_W{1'b1}} << {keff, 1'b0});
      nf = ((fwd_ff << 2) | WIN_W'(bcode)) & wmask;
      nr = ((rev_ff >> 2) | (WIN_W'(~bcode) << {keff - 5'd1, 1'b0})) & wmask;
      // replace each 16-bit chunk weight by its residue
      fold_pos = FOLD_W'(key_ff[15:0]) + FOLD_W'(key_ff[31:16]) * FOLD_W'(POS_F1)
               + FOLD_W'(key_ff[47:32]) * FOLD_W'(POS_F2)
               + FOLD_W'(key_ff[61:48]) * FOLD_W'(POS_F3);
      fold_step = FOLD_W'(key_ff[15:0]) + FOLD_W'(key_ff[31:16]) * FOLD_W'(STEP_F1)
                + FOLD_W'(key_ff[47:32]) * FOLD_W'(STEP_F2)
                + FOLD_W'(key_ff[61:48]) * FOLD_W'(STEP_F3);
      // second fold leaves less than twice the modulus
      red_pos = 18'(r1_ff[15:0]) + 18'(r1_ff[FOLD_W-1:16]) * 18'(POS_F1);
      red_step = 18'(r2_ff[15:0]) + 18'(r2_ff[FOLD_W-1:16]) * 18'(STEP_F1);
      psum = {2'b00, pos_ff} + {2'b00, step_ff};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (addr_ff == LAST) state_in = ST_IDLE;
         ST_IDLE: begin
            if (start) begin
               if (req_kind == KIND_READ) state_in = ST_READ;
               else if (!hdr_ff && isbase && loaded_ff >= keff - 5'd1) state_in = ST_CMP;
            end
         end
         ST_READ: state_in = ST_READ_OUT;
         ST_READ_OUT: state_in = ST_IDLE;
         ST_CMP: state_in = ((fwd_ff & mask_ff) == (rev_ff & mask_ff)) ? ST_IDLE : ST_DIV;
         ST_DIV: state_in = ST_FIX;
         ST_FIX: state_in = ST_PROBE;
         ST_PROBE: state_in = ST_CHECK;
         ST_CHECK: begin
            if (rd_data_ff == '0 || (rd_data_ff[WIN_W-1:0] & mask_ff) == key_ff
                || probes_ff == LAST) state_in = ST_IDLE;
            else state_in = ST_STEP;
         end
         ST_STEP: state_in = ST_PROBE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      k_in = k_ff; mask_in = mask_ff; fwd_in = fwd_ff; rev_in = rev_ff;
      loaded_in = loaded_ff; hdr_in = hdr_ff; uni_in = uni_ff; key_in = key_ff;
      addr_in = addr_ff; r1_in = r1_ff; r2_in = r2_ff;
      pos_in = pos_ff; step_in = step_ff; probes_in = probes_ff;
      rsp_valid_in = 1'b0; rsp_in = rsp_ff; oor_in = oor_ff;
      rd_en = 1'b0; rd_addr = addr_ff; wr_en = 1'b0; wr_addr = addr_ff; wr_data = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            addr_in = addr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (start) begin
               if (req_kind == KIND_READ) begin
                  oor_in = ({1'b0, req_index} >= 17'(TABLE_SIZE));
                  addr_in = req_index;
               end else if (hdr_ff) begin
                  if (req_character == CH_LF) hdr_in = 1'b0;
               end else if (isbase) begin
                  fwd_in = nf;
                  rev_in = nr;
                  if (loaded_ff < keff - 5'd1) loaded_in = loaded_ff + 5'd1;
               end else if (req_character != CH_LF && req_character != CH_CR) begin
                  if (req_character == CH_GT) hdr_in = 1'b1;
                  loaded_in = '0;
               end
            end
         end
         ST_READ: begin
            rd_en = 1'b1;
            rd_addr = addr_ff;
         end
         ST_READ_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_in = oor_ff ? '0 : rd_data_ff;
         end
         ST_CMP: begin
            uni_in = (fwd_ff > rev_ff) ? rev_ff : fwd_ff;
            key_in = ((fwd_ff > rev_ff) ? rev_ff : fwd_ff) & mask_ff;
         end
         ST_DIV: begin
            r1_in = fold_pos;
            r2_in = fold_step;
         end
         ST_FIX: begin
            pos_in = (red_pos >= RED_POS_M) ? AW'(red_pos - RED_POS_M) : AW'(red_pos);
            step_in = (red_step >= RED_STEP_M) ? AW'(red_step - RED_STEP_M + 18'd1)
                                               : AW'(red_step + 18'd1);
            probes_in = '0;
         end
         ST_PROBE: begin
            rd_en = 1'b1;
            rd_addr = pos_ff;
         end
         ST_CHECK: begin
            wr_addr = pos_ff;
            if (rd_data_ff == '0) begin
               wr_en = (uni_ff != '0);
               wr_data = {2'b00, uni_ff};
            end else if ((rd_data_ff[WIN_W-1:0] & mask_ff) == key_ff) begin
               wr_en = (rd_data_ff != {2'b00, uni_ff});
               wr_data = rd_data_ff | {1'b1, {(ENTRY_W-1){1'b0}}};
            end
         end
         ST_STEP: begin
            pos_in = (psum >= {1'b0, TSZ}) ? AW'(psum - {1'b0, TSZ}) : AW'(psum);
            probes_in = probes_ff + AW'(1);
         end
         default: ;
      endcase
      if (csr_write) begin
         if (csr_index == CSR_TUPLE_LENGTH) begin
            k_in = csr_data[4:0];
            loaded_in = '0;
         end else mask_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff <= '0;
         k_ff <= K_RESET;
         mask_ff <= MASK_RESET;
         fwd_ff <= '0;
         rev_ff <= '0;
         loaded_ff <= '0;
         hdr_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         k_ff <= k_in;
         mask_ff <= mask_in;
         fwd_ff <= fwd_in;
         rev_ff <= rev_in;
         loaded_ff <= loaded_in;
         hdr_ff <= hdr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      uni_ff <= uni_in; key_ff <= key_in;
      r1_ff <= r1_in; r2_ff <= r2_in; pos_ff <= pos_in; step_ff <= step_in;
      probes_ff <= probes_in; rsp_ff <= rsp_in; oor_ff <= oor_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_stored_tuple = rsp_ff[WIN_W-1:0];
   assign rsp_occupied = (rsp_ff != '0);
   assign rsp_conflicted = rsp_ff[ENTRY_W-1];

`ifndef SYNTHESIS
   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_READ_OUT)
      else $error("response without read");
   a_read_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_READ_OUT)
      else $error("read sequence broken");
   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_READ_OUT) |-> !wr_en)
      else $error("write during read");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives FASTA characters and slot reads into the k-mer context table under
// several window lengths and context masks. A scoreboard predicts every
// insertion into its own copy of the slot table and checks each read-back.
// ----------------------------------------------------------------------------
module testbench;
   import kcot_pkg::*;

   localparam int unsigned SLOTS = TABLE_SIZE;
   localparam int unsigned STALL_LIMIT = 400000;
   localparam logic [WIN_W-1:0] ALL_ONES = {WIN_W{1'b1}};

   typedef struct {
      logic [WIN_W-1:0] tuple;
      logic             occupied;
      logic             conflicted;
   } slot_read_type;

   class kmer_scoreboard_type;
      logic [ENTRY_W-1:0] slots [0:SLOTS-1];
      logic [WIN_W-1:0]   fwd, rev, mask;
      logic [4:0]         tuple_len;
      int unsigned        loaded;
      bit                 in_header;
      int                 filled[$];
      slot_read_type      reads_due[$];
      int unsigned        errors;

      function void clear();
         foreach (slots[i]) slots[i] = '0;
         fwd = '0;
         rev = '0;
         loaded = 0;
         in_header = 0;
         tuple_len = K_RESET;
         mask = MASK_RESET;
         errors = 0;
      endfunction

      function void write_reg(logic idx, logic [WIN_W-1:0] data);
         if (idx == CSR_TUPLE_LENGTH) begin
            tuple_len = data[4:0];
            loaded = 0;
         end else begin
            mask = data;
         end
      endfunction

      function void insert_kmer();
         logic [63:0] m, f, r, uni, key, pos, step, e;
         m = 64'(mask);
         f = 64'(fwd);
         r = 64'(rev);
         if ((f & m) == (r & m)) return;
         uni = (f > r) ? r : f;
         key = uni & m;
         pos = key % 64'(SLOTS);
         step = 64'd1 + key % 64'(SLOTS - 1);
         for (int unsigned i = 0; i < SLOTS; i++) begin
            e = slots[pos];
            if (e == 0) begin
               slots[pos] = uni;
               if (uni != 0) filled.push_back(int'(pos));
               return;
            end
            if ((e & m) == key) begin
               if (e != uni) slots[pos] = e | 64'h8000_0000_0000_0000;
               return;
            end
            pos = (pos + step) % 64'(SLOTS);
         end
      endfunction

      function void take_char(logic [7:0] c);
         int          b;
         int unsigned k;
         logic [63:0] wmask;
         if (in_header) begin
            if (c == CH_LF) in_header = 0;
            return;
         end
         case (c)
            "A", "a": b = 0;
            "C", "c": b = 1;
            "G", "g": b = 2;
            "T", "t": b = 3;
            default:  b = -1;
         endcase
         if (b >= 0) begin
            k = (tuple_len < 3) ? 3 : tuple_len;
            wmask = (64'd1 << (2 * k)) - 1;
            fwd = WIN_W'(((64'(fwd) << 2) | 64'(b)) & wmask);
            rev = WIN_W'(((64'(rev) >> 2) | (64'(b ^ 3) << (2 * (k - 1)))) & wmask);
            if (loaded < k - 1) loaded++;
            else insert_kmer();
            return;
         end
         if (c == CH_LF || c == CH_CR) return;
         if (c == CH_GT) in_header = 1;
         loaded = 0;
      endfunction

      function void note(logic kind, logic [7:0] c, logic [15:0] idx);
         slot_read_type s;
         logic [63:0]   e;
         if (kind == KIND_CHAR) begin
            take_char(c);
         end else begin
            e = (idx < SLOTS) ? slots[idx] : '0;
            s.tuple = e[WIN_W-1:0];
            s.occupied = (e != 0);
            s.conflicted = e[63];
            reads_due.push_back(s);
         end
      endfunction

      function void check(logic [WIN_W-1:0] tuple, logic occ, logic conf);
         slot_read_type s;
         if (reads_due.size() == 0) begin
            $error("unexpected read result tuple %h", tuple);
            errors++;
            return;
         end
         s = reads_due.pop_front();
         if (tuple !== s.tuple) begin
            $error("stored_tuple: expected %h actual %h", s.tuple, tuple);
            errors++;
         end
         if (occ !== s.occupied) begin
            $error("occupied: expected %0b actual %0b", s.occupied, occ);
            errors++;
         end
         if (conf !== s.conflicted) begin
            $error("conflicted: expected %0b actual %0b", s.conflicted, conf);
            errors++;
         end
      endfunction

      function int pending();
         return reads_due.size();
      endfunction
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             start = 0;
   logic             busy;
   logic             req_kind = 0;
   logic [7:0]       req_character = 0;
   logic [15:0]      req_index = 0;
   logic             rsp_valid;
   logic [WIN_W-1:0] rsp_stored_tuple;
   logic             rsp_occupied;
   logic             rsp_conflicted;
   logic             csr_write = 0;
   logic             csr_index = 0;
   logic [WIN_W-1:0] csr_data = 0;

   kmer_scoreboard_type sb = new();
   int unsigned         stall_count = 0;
   bit                  no_gaps = 0;

   kmer_context_object_table u_dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset || csr_write) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count > STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // results last one cycle from edge to edge, so the falling edge sees each once
   always @(negedge clock) begin
      if (!reset && rsp_valid) sb.check(rsp_stored_tuple, rsp_occupied, rsp_conflicted);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send(logic kind, logic [7:0] c, logic [15:0] idx);
      int g;
      start <= 1;
      req_kind <= kind;
      req_character <= c;
      req_index <= idx;
      do @(negedge clock); while (busy);
      @(posedge clock);
      sb.note(kind, c, idx);
      g = pick_gap();
      if (g > 0) begin
         start <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   // hold off until every read has returned and the block has gone quiet
   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      do @(negedge clock); while (busy);
      @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [WIN_W-1:0] data);
      drain();
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 0;
      sb.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic send_string(string s);
      foreach (s[i]) send(KIND_CHAR, s[i], 16'($urandom));
   endtask

   task automatic send_read();
      logic [15:0] idx;
      if (sb.filled.size() > 0 && $urandom_range(0, 2) != 0)
         idx = 16'(sb.filled[$urandom_range(0, sb.filled.size() - 1)]);
      else
         idx = 16'($urandom);
      send(KIND_READ, 8'($urandom), idx);
   endtask

   function automatic logic [7:0] rand_base();
      logic [7:0] b;
      case ($urandom_range(0, 3))
         0: b = "A";
         1: b = "C";
         2: b = "G";
         default: b = "T";
      endcase
      if ($urandom_range(0, 3) == 0) b = b | 8'h20;
      return b;
   endfunction

   task automatic random_items(int n);
      int sent, r, run;
      sent = 0;
      while (sent < n) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            run = $urandom_range(1, 40);
            repeat (run) send(KIND_CHAR, rand_base(), 16'($urandom));
            sent += run;
         end else if (r < 78) begin
            send_read();
            sent++;
         end else if (r < 86) begin
            send(KIND_CHAR, ($urandom_range(0, 1) != 0) ? CH_LF : CH_CR, 16'($urandom));
            sent++;
         end else if (r < 92) begin
            send(KIND_CHAR, CH_GT, 16'($urandom));
            run = $urandom_range(0, 8);
            repeat (run) send(KIND_CHAR, 8'($urandom), 16'($urandom));
            send(KIND_CHAR, CH_LF, 16'($urandom));
            sent += run + 2;
         end else begin
            send(KIND_CHAR, 8'($urandom), 16'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      sb.clear();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: shortest window, zero canonical value, header, stray bytes, reads
      write_reg(CSR_TUPLE_LENGTH, 62'd3);
      write_reg(CSR_CONTEXT_MASK, ALL_ONES);
      send_string("AAAAacgtACGTN");
      send_string(">hdr\nGATTC\r");
      send(KIND_CHAR, 8'hFF, 16'hFFFF);
      send(KIND_READ, 8'h00, 16'd0);
      send(KIND_READ, 8'hFF, 16'd65520);
      send(KIND_READ, 8'h00, 16'd65521);
      send(KIND_READ, 8'h00, 16'hFFFF);
      send_read();

      // mask clears the last base so contexts repeat with other objects
      write_reg(CSR_CONTEXT_MASK, 62'h3C);
      random_items(200);
      no_gaps = 1;
      write_reg(CSR_TUPLE_LENGTH, 62'd31);
      write_reg(CSR_CONTEXT_MASK, ALL_ONES);
      random_items(200);
      no_gaps = 0;
      drain();
      write_reg(CSR_TUPLE_LENGTH, WIN_W'({$urandom, $urandom}) & ~62'h1D | 62'd1);
      write_reg(CSR_CONTEXT_MASK, '0);
      random_items(150);
      write_reg(CSR_TUPLE_LENGTH, 62'd0);
      write_reg(CSR_CONTEXT_MASK, 62'h3C);
      random_items(200);
      write_reg(CSR_TUPLE_LENGTH, 62'd17);
      write_reg(CSR_CONTEXT_MASK, MASK_RESET);
      random_items(250);
      write_reg(CSR_TUPLE_LENGTH, 62'd4);
      write_reg(CSR_CONTEXT_MASK, WIN_W'({$urandom, $urandom}));
      random_items(250);
      write_reg(CSR_TUPLE_LENGTH, WIN_W'({$urandom, $urandom}));
      write_reg(CSR_CONTEXT_MASK, 62'h3FFF_FFFF_FFFF_FFF0);
      random_items(250);
      for (int i = 0; i < 40; i++) send_read();

      drain();
      repeat (500) @(posedge clock);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- kmer_context_object_table.f -----
hdl/kcot_pkg.sv
hdl/kmer_context_object_table.sv
dv/testbench.sv
